### rtl/core/pact_pkg.sv
// Shared constants for the page access counter tracker.
package pact_pkg;

  // Default sizing of the tracker
  localparam int PAGE_COUNT_DEF  = 64;
  localparam int NODE_COUNT_DEF  = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  // Request and result field widths
  localparam int PAGE_IDX_W = 6;
  localparam int NODE_IDX_W = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int THRESH_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RAISE_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_TOTAL   = 1'd1;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'hFFFF;

  // Wide enough for any counter or threshold compare
  localparam int CMP_W = 32;

endpackage

### rtl/core/pact_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pact_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the old contents on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/page_access_counter_tracker_unit.sv
// Page access counter tracker: per-page, per-node access counters and busiest page.
//
// Usage:
//   in_*  : one request per memory access, tdata = {node_index, page_index}.
//   out_* : one result per request, in request order.
//   cfg_* : register writes (threshold, compare select), only while idle.
// Each request reads its page's row of node counters and the page total into
// the RAM output registers, updates them and writes them back as it leaves
// the request stage, so one request is taken every cycle while out_tready is
// high; its result then goes to the result register. A request issued back to
// back to the same page picks up the row being written through a bypass register.
// Throughput: one request per cycle while out_tready is high, bounded by the
// single read port and single write port of the counter memories.
// Reset: a clearing pass zeroes both memories, one page per cycle, from page 0
// to PAGE_COUNT-1; in_tready stays low meanwhile (cfg writes still taken).
// Stall: while out_tready is low the result register holds, the request in
// flight holds with its read data, and in_tready drops once both are full.
module page_access_counter_tracker_unit #(
  parameter int PAGE_COUNT  = pact_pkg::PAGE_COUNT_DEF,
  parameter int NODE_COUNT  = pact_pkg::NODE_COUNT_DEF,
  parameter int COUNT_WIDTH = pact_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pact_pkg::IN_DATA_W-1:0]   in_tdata,   // [5:0] page_index, [9:6] node_index
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pact_pkg::OUT_DATA_W-1:0]  out_tdata,  // [0] threshold_raised,
                                                      // [6:1] busiest_page,
                                                      // [7] row_cleared, [8] rejected
  // configuration write port
  input  logic                             cfg_we,
  input  logic [pact_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pact_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import pact_pkg::*;

  localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int ROW_W  = NODE_COUNT * COUNT_WIDTH;

  typedef logic [NODE_COUNT-1:0][COUNT_WIDTH-1:0] row_t;
  typedef logic [COUNT_WIDTH-1:0]                 cnt_t;

  // configuration registers
  logic [THRESH_W-1:0] thresh_r;
  logic                cmp_total_r;

  // clearing pass
  logic              clr_active_r;
  logic [PAGE_W-1:0] clr_addr_r;

  // request in flight (read data is in the RAM output registers)
  logic                  s1_valid_r;
  logic [PAGE_IDX_W-1:0] s1_page_r;
  logic [NODE_IDX_W-1:0] s1_node_r;

  // bypass of the row written in the same edge this request was read
  logic fwd_r;
  row_t byp_row_r;
  cnt_t byp_total_r;

  // busiest page and a mirror of its total
  logic [PAGE_IDX_W-1:0] busiest_r, busiest_nxt;
  cnt_t                  best_r, best_nxt;

  // result register
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic accept, out_free, s1_adv;
  logic [ROW_W-1:0] row_rdata;
  cnt_t             total_rdata;
  row_t             row_cur, row_new, row_wr;
  cnt_t             total_cur, total_wr, nc, nt, sel_cnt;
  logic             rej, wrap, flag, item_we;
  logic [NODE_W-1:0] node_sel;

  logic              ram_we;
  logic [PAGE_W-1:0] ram_waddr, ram_raddr;
  logic [ROW_W-1:0]  ram_row_wdata;
  cnt_t              ram_total_wdata;

  // handshake
  assign out_free  = !out_tvalid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !clr_active_r && (!s1_valid_r || out_free);
  assign accept    = in_tvalid && in_tready;

  // update logic for the request in flight
  always_comb begin
    row_cur   = fwd_r ? byp_row_r   : row_t'(row_rdata);
    total_cur = fwd_r ? byp_total_r : total_rdata;
    node_sel  = NODE_W'(s1_node_r);

    rej  = (CMP_W'(s1_node_r) >= CMP_W'(NODE_COUNT)) ||
           (CMP_W'(s1_page_r) >= CMP_W'(PAGE_COUNT));
    wrap = (total_cur == '1);

    nc = row_cur[node_sel] + cnt_t'(1);
    nt = total_cur + cnt_t'(1);

    row_new           = row_cur;
    row_new[node_sel] = nc;

    // a wrapping total clears the whole row
    row_wr   = wrap ? '0 : row_new;
    total_wr = wrap ? '0 : nt;

    sel_cnt = cmp_total_r ? nt : nc;
    flag    = !rej && !wrap && (CMP_W'(sel_cnt) >= CMP_W'(thresh_r));

    item_we = s1_adv && !rej;

    busiest_nxt = busiest_r;
    best_nxt    = best_r;
    if (!rej && !wrap && (nt > best_r)) begin
      busiest_nxt = s1_page_r;
      best_nxt    = nt;
    end else if (!rej && wrap && (s1_page_r == busiest_r)) begin
      best_nxt = '0;
    end
  end

  // memory ports: clearing pass has the write port to itself
  always_comb begin
    ram_we          = clr_active_r || item_we;
    ram_waddr       = clr_active_r ? clr_addr_r : PAGE_W'(s1_page_r);
    ram_row_wdata   = clr_active_r ? '0 : ROW_W'(row_wr);
    ram_total_wdata = clr_active_r ? '0 : total_wr;
    ram_raddr       = PAGE_W'(in_tdata[PAGE_IDX_W-1:0]);
  end

  pact_ram #(
    .WIDTH (ROW_W),
    .DEPTH (PAGE_COUNT)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_row_wdata),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (row_rdata)
  );

  pact_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (PAGE_COUNT)
  ) u_total_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_total_wdata),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (total_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= THRESH_RESET;
      cmp_total_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RAISE_THRESHOLD: thresh_r    <= cfg_wdata[THRESH_W-1:0];
        REG_COMPARE_TOTAL:   cmp_total_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + PAGE_W'(1);
      if (clr_addr_r == PAGE_W'(PAGE_COUNT - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // request stage, bypass and busiest-page tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
      busiest_r  <= '0;
      best_r     <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        // hand the row being written to a back-to-back request to the same page
        fwd_r      <= item_we && (s1_page_r == in_tdata[PAGE_IDX_W-1:0]);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
        fwd_r      <= 1'b0;
      end
      if (s1_adv) begin
        busiest_r <= busiest_nxt;
        best_r    <= best_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_page_r   <= in_tdata[PAGE_IDX_W-1:0];
      s1_node_r   <= in_tdata[PAGE_IDX_W +: NODE_IDX_W];
      byp_row_r   <= row_wr;
      byp_total_r <= total_wr;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (s1_adv) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_tdata_r <= OUT_DATA_W'({rej, wrap && !rej, busiest_nxt, flag});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // no request enters while the clearing pass owns the memories
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_tready)
    else $error("request accepted during clearing pass");

  // the clearing pass and a row update never share the write port
  a_no_update_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |-> !clr_active_r)
    else $error("row update during clearing pass");

  // bypass data only ever serves a request in flight
  a_fwd_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("bypass set with no request in flight");

  // busiest page always names a tracked page
  a_busiest_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(busiest_r) < CMP_W'(PAGE_COUNT))
    else $error("busiest page out of range");

endmodule

### bench/tb.sv
// Self-checking testbench for the page access counter tracker unit.
`timescale 1ns / 1ps

module tb;
  import pact_pkg::*;

  localparam int PAGES = PAGE_COUNT_DEF;
  localparam int NODES = NODE_COUNT_DEF;
  localparam int STALL_LIMIT = 1000;  // cycles without any request or result moving

  typedef struct packed {
    logic [PAGE_IDX_W-1:0] page;
    logic [NODE_IDX_W-1:0] node;
  } access_req_t;

  typedef struct packed {
    logic                  raised;
    logic [PAGE_IDX_W-1:0] busiest;
    logic                  cleared;
    logic                  rejected;
  } access_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;      // [5:0] page_index, [9:6] node_index
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [0] raised, [6:1] busiest, [7] cleared, [8] rejected
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  page_access_counter_tracker_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus backlog, results still owed by the block, and bookkeeping
  access_req_t    access_backlog[$];
  access_result_t owed_results[$];
  bit             no_idle = 1'b0;   // both sides run flat out while set
  bit             req_taken = 1'b0; // request handshake seen at the last rising edge
  int             queued_cnt = 0;
  int             checked_cnt = 0;
  int             err_cnt = 0;
  int             reject_cnt = 0;
  int             clear_cnt = 0;
  int             raise_cnt = 0;
  int             quiet_cycles = 0;

  // Predictor state: a private copy of the counter memories and registers
  logic [COUNT_WIDTH_DEF-1:0] node_hits [PAGES][NODES];
  logic [COUNT_WIDTH_DEF-1:0] page_hits [PAGES];
  logic [PAGE_IDX_W-1:0]      hot_page;
  logic [THRESH_W-1:0]        thresh_q;
  logic                       use_total_q;

  // Apply one accepted access to the predictor state and return what the block
  // should report for it.
  function automatic access_result_t tally_access(input logic [PAGE_IDX_W-1:0] pg,
                                                  input logic [NODE_IDX_W-1:0] nd);
    access_result_t r;
    logic [COUNT_WIDTH_DEF-1:0] best, new_total, new_node, picked;
    r = '0;
    if (nd >= NODES || pg >= PAGES) begin
      // Unknown node: nothing moves, the busiest page is only echoed
      r.rejected = 1'b1;
    end else if (page_hits[pg] == '1) begin
      // The total would wrap: wipe the row, leave the busiest page alone
      for (int n = 0; n < NODES; n++) node_hits[pg][n] = '0;
      page_hits[pg] = '0;
      r.cleared = 1'b1;
    end else begin
      // Read the busiest page's total before this page's total is updated
      best = page_hits[hot_page];
      new_total = page_hits[pg] + 1'b1;
      new_node = node_hits[pg][nd] + 1'b1;
      node_hits[pg][nd] = new_node;
      page_hits[pg] = new_total;
      if (new_total > best) hot_page = pg;
      picked = use_total_q ? new_total : new_node;
      r.raised = (picked >= thresh_q);
    end
    r.busiest = hot_page;
    return r;
  endfunction

  // Driver: present the next request at the falling edge, hold it until taken.
  always @(negedge clk) begin : drive
    access_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || req_taken) begin
        if (access_backlog.size() > 0 && (no_idle || $urandom_range(0, 99) >= 32)) begin
          nxt = access_backlog.pop_front();
          in_tdata <= {{(IN_DATA_W - PAGE_IDX_W - NODE_IDX_W){1'b0}}, nxt.node, nxt.page};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      // Stall the result side at random, except during a flat-out stretch
      out_tready <= no_idle || ($urandom_range(0, 99) >= 32);
    end
  end

  // Monitor: track register writes, predict on each accepted request and
  // check each accepted result against the oldest prediction.
  always @(posedge clk) begin : observe
    access_result_t want, got;
    if (!rst_n) begin
      for (int p = 0; p < PAGES; p++) begin
        page_hits[p] = '0;
        for (int n = 0; n < NODES; n++) node_hits[p][n] = '0;
      end
      hot_page = '0;
      thresh_q = THRESH_RESET;
      use_total_q = 1'b0;
      req_taken = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RAISE_THRESHOLD: thresh_q = cfg_wdata[THRESH_W-1:0];
          REG_COMPARE_TOTAL:   use_total_q = cfg_wdata[0];
          default: ;
        endcase
      end
      req_taken = in_tvalid && in_tready;
      if (req_taken) begin
        want = tally_access(in_tdata[PAGE_IDX_W-1:0],
                            in_tdata[PAGE_IDX_W +: NODE_IDX_W]);
        owed_results.push_back(want);
        reject_cnt += want.rejected;
        clear_cnt += want.cleared;
        raise_cnt += want.raised;
      end
      if (out_tvalid && out_tready) begin
        got.raised = out_tdata[0];
        got.busiest = out_tdata[6:1];
        got.cleared = out_tdata[7];
        got.rejected = out_tdata[8];
        if (owed_results.size() == 0) begin
          $error("result with no request outstanding: tdata %h", out_tdata);
          err_cnt++;
        end else begin
          want = owed_results.pop_front();
          if (got.raised !== want.raised) begin
            $error("threshold_raised: expected %0d, got %0d", want.raised, got.raised);
            err_cnt++;
          end
          if (got.busiest !== want.busiest) begin
            $error("busiest_page: expected %0d, got %0d", want.busiest, got.busiest);
            err_cnt++;
          end
          if (got.cleared !== want.cleared) begin
            $error("row_cleared: expected %0d, got %0d", want.cleared, got.cleared);
            err_cnt++;
          end
          if (got.rejected !== want.rejected) begin
            $error("rejected: expected %0d, got %0d", want.rejected, got.rejected);
            err_cnt++;
          end
        end
        checked_cnt++;
      end
    end
  end

  // Watchdog: give up when neither channel has moved for too long. The
  // clearing pass after reset and the random stalls stay far below the limit.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_access(input int pg, input int nd);
    access_req_t r;
    r.page = pg[PAGE_IDX_W-1:0];
    r.node = nd[NODE_IDX_W-1:0];
    access_backlog.push_back(r);
    queued_cnt++;
  endtask

  // Mostly known nodes, some rejected ones; part of the traffic hits a few hot
  // pages so the counters climb far enough to cross the thresholds.
  task automatic queue_random(input int count, input int hot_pct);
    int pg, nd;
    for (int i = 0; i < count; i++) begin
      pg = ($urandom_range(0, 99) < hot_pct) ? $urandom_range(0, 3) : $urandom_range(0, PAGES - 1);
      nd = ($urandom_range(0, 99) < 80) ? $urandom_range(0, NODES - 1) : $urandom_range(NODES, 15);
      queue_access(pg, nd);
    end
  endtask

  // Hold off until every request has come back, then let the pipeline settle.
  task automatic drain;
    while (checked_cnt != queued_cnt) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Threshold zero: every access from a known node raises the flag. Walk the field
    // extremes and alternating bit patterns, plus out-of-range nodes.
    write_reg(REG_RAISE_THRESHOLD, 0);
    write_reg(REG_COMPARE_TOTAL, 0);
    queue_access(0, 0);
    queue_access(63, 7);
    queue_access(63, 8);
    queue_access(0, 15);
    queue_access(42, 5);
    queue_access(21, 2);
    queue_access(42, 10);
    queue_access(21, 1);
    queue_access(63, 6);
    drain();

    // Small per-node threshold: flag only from a node's second access on
    write_reg(REG_RAISE_THRESHOLD, 2);
    queue_access(5, 1);
    queue_access(5, 1);
    queue_access(5, 3);
    queue_access(5, 1);
    queue_access(6, 4);
    drain();

    // Same threshold on the page total
    write_reg(REG_COMPARE_TOTAL, 1);
    queue_access(6, 0);
    queue_access(7, 3);
    queue_access(5, 9);
    queue_access(7, 3);
    drain();

    // Back-to-back accesses to one page at full rate, so each one after the first
    // picks up the row its predecessor is still writing back.
    write_reg(REG_RAISE_THRESHOLD, 8);
    no_idle = 1'b1;
    for (int i = 0; i < 12; i++) queue_access(9, $urandom_range(0, NODES - 1));
    queue_access(0, 1);
    queue_access(9, 3);
    drain();
    no_idle = 1'b0;

    // Random traffic under several register settings; each phase boundary
    // holds the sender until every result is back.
    write_reg(REG_RAISE_THRESHOLD, $urandom_range(1, 3));
    write_reg(REG_COMPARE_TOTAL, 0);
    queue_random(130, 50);
    drain();

    write_reg(REG_RAISE_THRESHOLD, $urandom_range(10, 40));
    write_reg(REG_COMPARE_TOTAL, 1);
    queue_random(130, 40);
    drain();

    write_reg(REG_RAISE_THRESHOLD, 0);
    no_idle = 1'b1;
    queue_random(120, 30);
    drain();
    no_idle = 1'b0;

    write_reg(REG_RAISE_THRESHOLD, $urandom_range(0, 65535));
    queue_random(20, 50);
    drain();

    write_reg(REG_RAISE_THRESHOLD, 65535);
    write_reg(REG_COMPARE_TOTAL, 0);
    queue_random(100, 50);
    drain();

    repeat (5) @(posedge clk);
    $display("Checked %0d results: %0d rejected, %0d row clears, %0d threshold hits,",
             checked_cnt, reject_cnt, clear_cnt, raise_cnt);
    $display("across per-node and total compares with thresholds from 0 to 65535.");
    if (err_cnt == 0 && owed_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/pact_pkg.sv
rtl/core/pact_ram.sv
rtl/core/page_access_counter_tracker_unit.sv
bench/tb.sv
